### hdl/rsi_pkg.sv
// rsi_pkg: shared types, constants and saturating fixed-point helpers for the
// ray / surface segment intersection block. No dependencies.
package rsi_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int EXT_W     = 31;
    localparam int EPS_W     = 16;
    localparam int Q_W       = 64;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

    // stream packing
    localparam int IN_W       = 8 * COORD_W + EXT_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * COORD_W;
    localparam int OUT_TUSER_W = 2;

    // unit latencies (enabled edges from operands to registered result)
    localparam int DIV_N_W    = Q_W + FRAC_BITS;
    localparam int DIV_LAT    = DIV_N_W + 2;
    localparam int MUL_LAT    = 4;
    localparam int SQRT_STEPS = DIV_N_W / 2;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    // pipeline positions of the main path
    localparam int K_SLOPE = DIV_LAT;
    localparam int K_ICPT  = K_SLOPE + MUL_LAT;
    localparam int K_SEL   = K_ICPT + 1;
    localparam int K_DIV2  = K_SEL + 1;
    localparam int K_PX    = K_DIV2 + DIV_LAT;
    localparam int K_PY    = K_PX + MUL_LAT;
    localparam int K_DOT   = K_PY + 1;
    localparam int K_SUM   = K_DOT + MUL_LAT;
    localparam int K_CMP   = K_SUM + 1;

    // positions of the surface length / limit path
    localparam int K_SQ  = MUL_LAT + 1;
    localparam int K_LEN = K_SQ + SQRT_LAT;
    localparam int K_LIM = K_LEN + MUL_LAT;
    localparam int LIM_DLY = K_CMP - K_LIM;

    typedef logic signed [Q_W-1:0]     q_t;
    typedef logic        [Q_W-1:0]     mag_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam q_t C_HI  = {{(Q_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam q_t C_LO  = {{(Q_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        coord_t               rsx;
        coord_t               rsy;
        coord_t               rex;
        coord_t               rey;
        coord_t               ssx;
        coord_t               ssy;
        coord_t               sex;
        coord_t               sey;
        logic [EXT_W-1:0]     ext;
    } item_t;

    // how the crossing point is formed
    typedef enum logic [2:0] {
        KIND_PAR  = 3'd0,   // parallel: no point
        KIND_FIX  = 3'd1,   // both coordinates taken from the inputs
        KIND_DIVX = 3'd2,   // x from the divider, y fixed
        KIND_MULF = 3'd3,   // x fixed, y = a*x + b
        KIND_GEN  = 3'd4    // x from the divider, y = a1*x + b1
    } kind_t;

    function automatic q_t cq(coord_t c);
        return {{(Q_W-COORD_W){c[COORD_W-1]}}, c};
    endfunction

    function automatic q_t cdiff(coord_t x, coord_t y);
        logic signed [COORD_W:0] d;
        d = {x[COORD_W-1], x} - {y[COORD_W-1], y};
        return {{(Q_W-COORD_W-1){d[COORD_W]}}, d};
    endfunction

    function automatic q_t sadd(q_t a, q_t b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
            return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    function automatic q_t ssub(q_t a, q_t b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
            return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    function automatic mag_t qmag(q_t a);
        return a[Q_W-1] ? (mag_t'(0) - mag_t'(a)) : mag_t'(a);
    endfunction

    function automatic q_t from_mag(logic neg, mag_t m);
        if (neg)
            return m[Q_W-1] ? Q_MIN : q_t'(mag_t'(0) - m);
        return m[Q_W-1] ? Q_MAX : q_t'(m);
    endfunction

    function automatic logic near(q_t u, q_t v, q_t e);
        q_t d;
        d = ssub(u, v);
        return (d > -e) && (d < e);
    endfunction

    function automatic coord_t clamp_c(q_t v);
        if (v > C_HI)
            return C_HI[COORD_W-1:0];
        if (v < C_LO)
            return C_LO[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

endpackage

### hdl/rsi_mulq.sv
// rsi_mulq: pipelined saturating Q-format multiply, four 32x32 partial products.
// Depends on rsi_pkg.
module rsi_mulq (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::q_t   a,
    input  rsi_pkg::q_t   b,
    output rsi_pkg::q_t   p
);
    import rsi_pkg::*;

    localparam int H_W = Q_W / 2;

    logic               neg_reg [0:2];
    mag_t               am_reg;
    mag_t               bm_reg;
    logic [Q_W-1:0]     pp00_reg;
    logic [Q_W-1:0]     pp01_reg;
    logic [Q_W-1:0]     pp10_reg;
    logic [Q_W-1:0]     pp11_reg;
    logic [2*Q_W-1:0]   sum_reg;
    q_t                 p_reg;
    logic [2*Q_W-1:0]   sh;
    mag_t               m;

    always_comb
    begin
        sh = sum_reg >> FRAC_BITS;
        m  = (|sh[2*Q_W-1:Q_W]) ? {Q_W{1'b1}} : sh[Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= a[Q_W-1] ^ b[Q_W-1];
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
            am_reg     <= qmag(a);
            bm_reg     <= qmag(b);
            pp00_reg   <= am_reg[H_W-1:0] * bm_reg[H_W-1:0];
            pp01_reg   <= am_reg[H_W-1:0] * bm_reg[Q_W-1:H_W];
            pp10_reg   <= am_reg[Q_W-1:H_W] * bm_reg[H_W-1:0];
            pp11_reg   <= am_reg[Q_W-1:H_W] * bm_reg[Q_W-1:H_W];
            sum_reg    <= {{Q_W{1'b0}}, pp00_reg}
                        + {{H_W{1'b0}}, pp01_reg, {H_W{1'b0}}}
                        + {{H_W{1'b0}}, pp10_reg, {H_W{1'b0}}}
                        + {pp11_reg, {Q_W{1'b0}}};
            p_reg      <= from_mag(neg_reg[2], m);
        end
    end

    assign p = p_reg;

endmodule

### hdl/rsi_divq.sv
// rsi_divq: pipelined saturating Q-format divide, one quotient bit per stage.
// Depends on rsi_pkg.
module rsi_divq (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::q_t   n,
    input  rsi_pkg::q_t   d,
    output rsi_pkg::q_t   q
);
    import rsi_pkg::*;

    typedef struct packed {
        mag_t                 r;
        logic [DIV_N_W-1:0]   nsh;
        logic [DIV_N_W-1:0]   qb;
        mag_t                 dm;
        logic                 neg;
        logic                 dz;
        logic                 nz;
        logic                 nsign;
    } dstage_t;

    dstage_t    st_reg [0:DIV_N_W];
    dstage_t    st_next [1:DIV_N_W];
    q_t         q_reg;
    dstage_t    last;
    mag_t       qm;

    always_comb
    begin
        for (int j = 1; j <= DIV_N_W; j++)
        begin
            logic [Q_W:0] rt;
            logic [Q_W:0] rd;
            logic         ge;
            rt = {st_reg[j-1].r, st_reg[j-1].nsh[DIV_N_W-1]};
            rd = rt - {1'b0, st_reg[j-1].dm};
            ge = rt >= {1'b0, st_reg[j-1].dm};
            st_next[j]     = st_reg[j-1];
            st_next[j].r   = ge ? rd[Q_W-1:0] : rt[Q_W-1:0];
            st_next[j].nsh = st_reg[j-1].nsh << 1;
            st_next[j].qb  = {st_reg[j-1].qb[DIV_N_W-2:0], ge};
        end
        last = st_reg[DIV_N_W];
        qm   = (|last.qb[DIV_N_W-1:Q_W]) ? {Q_W{1'b1}} : last.qb[Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].r     <= '0;
            st_reg[0].nsh   <= {qmag(n), {FRAC_BITS{1'b0}}};
            st_reg[0].qb    <= '0;
            st_reg[0].dm    <= qmag(d);
            st_reg[0].neg   <= n[Q_W-1] ^ d[Q_W-1];
            st_reg[0].dz    <= (d == '0);
            st_reg[0].nz    <= (n == '0);
            st_reg[0].nsign <= n[Q_W-1];
            for (int j = 1; j <= DIV_N_W; j++)
                st_reg[j] <= st_next[j];
            if (last.dz)
                q_reg <= last.nz ? '0 : (last.nsign ? Q_MIN : Q_MAX);
            else
                q_reg <= from_mag(last.neg, qm);
        end
    end

    assign q = q_reg;

endmodule

### hdl/rsi_sqrt.sv
// rsi_sqrt: pipelined floor(sqrt(s << FRAC_BITS)), one root bit per stage.
// Depends on rsi_pkg.
module rsi_sqrt (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::q_t   s,
    output rsi_pkg::q_t   root
);
    import rsi_pkg::*;

    localparam int R_W   = SQRT_STEPS;
    localparam int REM_W = R_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [R_W-1:0]       rt;
        logic [DIV_N_W-1:0]   nsh;
    } sstage_t;

    sstage_t    st_reg [0:SQRT_STEPS];
    sstage_t    st_next [1:SQRT_STEPS];

    always_comb
    begin
        for (int j = 1; j <= SQRT_STEPS; j++)
        begin
            logic [REM_W+1:0] cur;
            logic [REM_W+1:0] trial;
            logic [REM_W+1:0] diff;
            logic             ge;
            cur   = {st_reg[j-1].rem, st_reg[j-1].nsh[DIV_N_W-1:DIV_N_W-2]};
            trial = {2'b00, st_reg[j-1].rt, 2'b01};
            diff  = cur - trial;
            ge    = cur >= trial;
            st_next[j].rem = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
            st_next[j].rt  = {st_reg[j-1].rt[R_W-2:0], ge};
            st_next[j].nsh = st_reg[j-1].nsh << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem <= '0;
            st_reg[0].rt  <= '0;
            st_reg[0].nsh <= (s[Q_W-1] || s == '0) ? '0
                           : {mag_t'(s), {FRAC_BITS{1'b0}}};
            for (int j = 1; j <= SQRT_STEPS; j++)
                st_reg[j] <= st_next[j];
        end
    end

    assign root = q_t'({{(Q_W-R_W){1'b0}}, st_reg[SQRT_STEPS].rt});

endmodule

### hdl/ray_segment_intersection.sv
// ray_segment_intersection: top level, streaming ray / surface segment intersection.
// Depends on rsi_pkg, rsi_mulq, rsi_divq, rsi_sqrt.
//
// Takes one ray segment and one surface segment per item, all coordinates
// signed Q16.16, and returns one result item per input item in order. Both
// lines are sorted into vertical (zero run), horizontal (|slope| < epsilon)
// or sloped; parallel pairs report coincide when their offsets agree within
// epsilon, otherwise the crossing is solved and counted as a hit when it lies
// strictly inside the ray and within the surface stretched by surf_extension.
// A new item is accepted every clock cycle while the skid register is empty. The
// depth is set by the two chained bit-per-stage dividers (slope, then crossing
// x) plus three chained multipliers and the input, intercept, case select,
// point and sum registers. While the output stalls the pipeline keeps moving
// until a finished result lands in a one-item skid register behind the output
// register; from then on the whole pipeline and s_axis_tready hold until the
// skid drains; items are still taken while a result waits and the skid is empty.
// epsilon (reset 16 LSBs) is written over the cfg port; the user must write it
// only while the block holds no items, and the block does not enforce this.
module ray_segment_intersection (
    input  logic                              clk,
    input  logic                              rst_n,
    // rsx, rsy, rex, rey, ssx, ssy, sex, sey (32 b each), surf_extension (31 b)
    input  logic [rsi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hit_x (32 b), hit_y (32 b)
    output logic [rsi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // hit, coincide
    output logic [rsi_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rsi_pkg::EPS_W-1:0]         cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);
    import rsi_pkg::*;

    typedef struct packed {
        q_t a1;
        q_t a2;
    } slope_t;

    typedef struct packed {
        q_t   a1;
        q_t   a2;
        q_t   b1;
        q_t   b2;
        logic h1;
        logic h2;
    } line_t;

    typedef struct packed {
        kind_t kind;
        q_t    px_fix;
        q_t    py_fix;
        q_t    ma;
        q_t    mb_fix;
        q_t    badd;
        logic  coin;
    } dctl_t;

    typedef struct packed {
        kind_t kind;
        q_t    px;
        q_t    py_fix;
        q_t    badd;
        logic  coin;
    } pctl_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        logic   computed;
        logic   coin;
    } point_t;

    typedef struct packed {
        logic                   hit;
        logic                   coin;
        coord_t                 px;
        coord_t                 py;
    } res_t;

    // ---------------------------------------------------------------- control
    logic [EPS_W-1:0] eps_reg;
    q_t               e_q;
    logic             en;
    logic             vld_reg [0:K_CMP];
    item_t            ctx_reg [0:K_CMP];
    item_t            in_item;

    res_t             out_reg;
    logic             out_vld_reg;
    res_t             skid_reg;
    logic             skid_vld_reg;
    res_t             cand;

    assign cfg_ready     = 1'b1;
    assign e_q           = q_t'({{(Q_W-EPS_W){1'b0}}, eps_reg});
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_valid)
            eps_reg <= cfg_data;
    end

    always_comb
    begin
        in_item.rsx = s_axis_tdata[0*COORD_W +: COORD_W];
        in_item.rsy = s_axis_tdata[1*COORD_W +: COORD_W];
        in_item.rex = s_axis_tdata[2*COORD_W +: COORD_W];
        in_item.rey = s_axis_tdata[3*COORD_W +: COORD_W];
        in_item.ssx = s_axis_tdata[4*COORD_W +: COORD_W];
        in_item.ssy = s_axis_tdata[5*COORD_W +: COORD_W];
        in_item.sex = s_axis_tdata[6*COORD_W +: COORD_W];
        in_item.sey = s_axis_tdata[7*COORD_W +: COORD_W];
        in_item.ext = s_axis_tdata[8*COORD_W +: EXT_W];
    end

    // valid bits travel alongside the item context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= K_CMP; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i <= K_CMP; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_item;
            for (int i = 1; i <= K_CMP; i++)
                ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    // ---------------------------------------------------------- slopes (pos 0)
    q_t dx1, dy1, dx2, dy2;
    q_t div_a1, div_a2;
    q_t len_p1, len_p2;

    assign dx1 = cdiff(ctx_reg[0].rex, ctx_reg[0].rsx);
    assign dy1 = cdiff(ctx_reg[0].rey, ctx_reg[0].rsy);
    assign dx2 = cdiff(ctx_reg[0].sex, ctx_reg[0].ssx);
    assign dy2 = cdiff(ctx_reg[0].sey, ctx_reg[0].ssy);

    rsi_divq u_div_a1 (.clk(clk), .en(en), .n(dy1), .d(dx1), .q(div_a1));
    rsi_divq u_div_a2 (.clk(clk), .en(en), .n(dy2), .d(dx2), .q(div_a2));

    // surface length and extension limit, side path
    rsi_mulq u_mul_l1 (.clk(clk), .en(en), .a(dx2), .b(dx2), .p(len_p1));
    rsi_mulq u_mul_l2 (.clk(clk), .en(en), .a(dy2), .b(dy2), .p(len_p2));

    q_t sq_reg;
    q_t len;
    q_t ext_q;
    q_t lim_base;
    q_t lim;
    q_t lim_dly_reg [0:LIM_DLY-1];

    rsi_sqrt u_sqrt (.clk(clk), .en(en), .s(sq_reg), .root(len));

    assign ext_q    = q_t'({{(Q_W-EXT_W){1'b0}}, ctx_reg[K_LEN].ext});
    assign lim_base = sadd(ext_q, len);

    rsi_mulq u_mul_lim (.clk(clk), .en(en), .a(lim_base), .b(ext_q), .p(lim));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg         <= sadd(len_p1, len_p2);
            lim_dly_reg[0] <= lim;
            for (int i = 1; i < LIM_DLY; i++)
                lim_dly_reg[i] <= lim_dly_reg[i-1];
        end
    end

    // ---------------------------------------------------- intercepts (K_SLOPE)
    slope_t slope_w;
    slope_t slope_dly_reg [0:MUL_LAT-1];
    q_t     prod_b1, prod_b2;
    logic   v1_s, v2_s;

    assign v1_s = ctx_reg[K_SLOPE].rex == ctx_reg[K_SLOPE].rsx;
    assign v2_s = ctx_reg[K_SLOPE].sex == ctx_reg[K_SLOPE].ssx;
    assign slope_w.a1 = v1_s ? '0 : div_a1;
    assign slope_w.a2 = v2_s ? '0 : div_a2;

    rsi_mulq u_mul_b1 (.clk(clk), .en(en), .a(slope_w.a1), .b(cq(ctx_reg[K_SLOPE].rsx)),
                       .p(prod_b1));
    rsi_mulq u_mul_b2 (.clk(clk), .en(en), .a(slope_w.a2), .b(cq(ctx_reg[K_SLOPE].ssx)),
                       .p(prod_b2));

    line_t line_w;
    line_t line_reg;
    logic  v1_i, v2_i;

    always_comb
    begin
        v1_i      = ctx_reg[K_ICPT].rex == ctx_reg[K_ICPT].rsx;
        v2_i      = ctx_reg[K_ICPT].sex == ctx_reg[K_ICPT].ssx;
        line_w.a1 = slope_dly_reg[MUL_LAT-1].a1;
        line_w.a2 = slope_dly_reg[MUL_LAT-1].a2;
        line_w.b1 = v1_i ? '0 : ssub(cq(ctx_reg[K_ICPT].rsy), prod_b1);
        line_w.b2 = v2_i ? '0 : ssub(cq(ctx_reg[K_ICPT].ssy), prod_b2);
        line_w.h1 = !v1_i && (line_w.a1 > -e_q) && (line_w.a1 < e_q);
        line_w.h2 = !v2_i && (line_w.a2 > -e_q) && (line_w.a2 < e_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slope_dly_reg[0] <= slope_w;
            for (int i = 1; i < MUL_LAT; i++)
                slope_dly_reg[i] <= slope_dly_reg[i-1];
            line_reg <= line_w;
        end
    end

    // ---------------------------------------------------- case select (K_SEL)
    item_t  cs;
    logic   v1_c, v2_c;
    dctl_t  dctl_w;
    q_t     num_w, den_w;
    dctl_t  dctl_reg;
    q_t     num_reg, den_reg;

    always_comb
    begin
        cs     = ctx_reg[K_SEL];
        v1_c   = cs.rex == cs.rsx;
        v2_c   = cs.sex == cs.ssx;
        dctl_w = '{kind: KIND_PAR, default: '0};
        num_w  = '0;
        den_w  = '0;
        if (line_reg.h1)
        begin
            if (line_reg.h2)
                dctl_w.coin = near(cq(cs.rsy), cq(cs.ssy), e_q);
            else if (v2_c)
            begin
                dctl_w.kind   = KIND_FIX;
                dctl_w.px_fix = cq(cs.ssx);
                dctl_w.py_fix = cq(cs.rsy);
            end
            else
            begin
                dctl_w.kind   = KIND_DIVX;
                dctl_w.py_fix = cq(cs.rsy);
                num_w         = ssub(cq(cs.rsy), line_reg.b2);
                den_w         = line_reg.a2;
            end
        end
        else if (v1_c)
        begin
            if (line_reg.h2)
            begin
                dctl_w.kind   = KIND_FIX;
                dctl_w.px_fix = cq(cs.rsx);
                dctl_w.py_fix = cq(cs.ssy);
            end
            else if (v2_c)
                dctl_w.coin = near(cq(cs.rsx), cq(cs.ssx), e_q);
            else
            begin
                dctl_w.kind   = KIND_MULF;
                dctl_w.px_fix = cq(cs.rsx);
                dctl_w.ma     = line_reg.a2;
                dctl_w.mb_fix = cq(cs.rsx);
                dctl_w.badd   = line_reg.b2;
            end
        end
        else
        begin
            if (line_reg.h2)
            begin
                dctl_w.kind   = KIND_DIVX;
                dctl_w.py_fix = cq(cs.ssy);
                num_w         = ssub(cq(cs.ssy), line_reg.b1);
                den_w         = line_reg.a1;
            end
            else if (v2_c)
            begin
                dctl_w.kind   = KIND_MULF;
                dctl_w.px_fix = cq(cs.ssx);
                dctl_w.ma     = line_reg.a1;
                dctl_w.mb_fix = cq(cs.ssx);
                dctl_w.badd   = line_reg.b1;
            end
            else if (near(line_reg.a1, line_reg.a2, e_q))
                dctl_w.coin = near(line_reg.b1, line_reg.b2, e_q);
            else
            begin
                dctl_w.kind = KIND_GEN;
                dctl_w.ma   = line_reg.a1;
                dctl_w.badd = line_reg.b1;
                num_w       = ssub(line_reg.b2, line_reg.b1);
                den_w       = ssub(line_reg.a1, line_reg.a2);
            end
        end
    end

    // ------------------------------------------------ crossing x (K_DIV2..)
    q_t    div_px;
    dctl_t dctl_dly_reg [0:DIV_LAT-1];

    rsi_divq u_div_px (.clk(clk), .en(en), .n(num_reg), .d(den_reg), .q(div_px));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dctl_reg        <= dctl_w;
            num_reg         <= num_w;
            den_reg         <= den_w;
            dctl_dly_reg[0] <= dctl_reg;
            for (int i = 1; i < DIV_LAT; i++)
                dctl_dly_reg[i] <= dctl_dly_reg[i-1];
        end
    end

    // ----------------------------------------------------- crossing y (K_PX)
    dctl_t dx_c;
    pctl_t pctl_w;
    pctl_t pctl_dly_reg [0:MUL_LAT-1];
    q_t    mb_w;
    q_t    prod_py;

    always_comb
    begin
        dx_c          = dctl_dly_reg[DIV_LAT-1];
        pctl_w.kind   = dx_c.kind;
        pctl_w.py_fix = dx_c.py_fix;
        pctl_w.badd   = dx_c.badd;
        pctl_w.coin   = dx_c.coin;
        mb_w          = dx_c.mb_fix;
        case (dx_c.kind)
            KIND_GEN:
            begin
                mb_w      = div_px;
                pctl_w.px = div_px;
            end
            KIND_DIVX:
                pctl_w.px = div_px;
            default:
                pctl_w.px = dx_c.px_fix;
        endcase
    end

    rsi_mulq u_mul_py (.clk(clk), .en(en), .a(dx_c.ma), .b(mb_w), .p(prod_py));

    pctl_t  pc;
    point_t pt_w;
    point_t pt_reg;
    q_t     py_w;

    always_comb
    begin
        pc               = pctl_dly_reg[MUL_LAT-1];
        pt_w.computed    = 1'b1;
        pt_w.coin        = pc.coin;
        case (pc.kind)
            KIND_GEN, KIND_MULF:
                py_w = sadd(prod_py, pc.badd);
            KIND_DIVX, KIND_FIX:
                py_w = pc.py_fix;
            default:
            begin
                py_w          = '0;
                pt_w.computed = 1'b0;
            end
        endcase
        pt_w.px = clamp_c(pc.px);
        pt_w.py = clamp_c(py_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pctl_dly_reg[0] <= pctl_w;
            for (int i = 1; i < MUL_LAT; i++)
                pctl_dly_reg[i] <= pctl_dly_reg[i-1];
            pt_reg <= pt_w;
        end
    end

    // -------------------------------------------------- segment tests (K_DOT)
    item_t  cd;
    q_t     d_rx0, d_rx1, d_ry0, d_ry1, d_sx0, d_sx1, d_sy0, d_sy1;
    q_t     m_rx, m_ry, m_sx, m_sy;
    point_t pt_dly_reg [0:MUL_LAT];
    q_t     dr_reg, ds_reg;

    assign cd    = ctx_reg[K_DOT];
    assign d_rx0 = cdiff(pt_reg.px, cd.rsx);
    assign d_rx1 = cdiff(pt_reg.px, cd.rex);
    assign d_ry0 = cdiff(pt_reg.py, cd.rsy);
    assign d_ry1 = cdiff(pt_reg.py, cd.rey);
    assign d_sx0 = cdiff(pt_reg.px, cd.ssx);
    assign d_sx1 = cdiff(pt_reg.px, cd.sex);
    assign d_sy0 = cdiff(pt_reg.py, cd.ssy);
    assign d_sy1 = cdiff(pt_reg.py, cd.sey);

    rsi_mulq u_mul_rx (.clk(clk), .en(en), .a(d_rx0), .b(d_rx1), .p(m_rx));
    rsi_mulq u_mul_ry (.clk(clk), .en(en), .a(d_ry0), .b(d_ry1), .p(m_ry));
    rsi_mulq u_mul_sx (.clk(clk), .en(en), .a(d_sx0), .b(d_sx1), .p(m_sx));
    rsi_mulq u_mul_sy (.clk(clk), .en(en), .a(d_sy0), .b(d_sy1), .p(m_sy));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_dly_reg[0] <= pt_reg;
            for (int i = 1; i <= MUL_LAT; i++)
                pt_dly_reg[i] <= pt_dly_reg[i-1];
            dr_reg <= sadd(m_rx, m_ry);
            ds_reg <= sadd(m_sx, m_sy);
        end
    end

    // ------------------------------------------------------ verdict (K_CMP)
    point_t pf;

    always_comb
    begin
        pf        = pt_dly_reg[MUL_LAT];
        cand.coin = pf.coin;
        cand.px   = pf.px;
        cand.py   = pf.py;
        if (pf.computed)
            cand.hit = (dr_reg < 0) && (ds_reg < lim_dly_reg[LIM_DLY-1]);
        else
            cand.hit = pf.coin;
    end

    // output register with one-item skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
                out_vld_reg <= vld_reg[K_CMP];
        end
        else if (en && vld_reg[K_CMP])
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_axis_tready)
            out_reg <= skid_vld_reg ? skid_reg : cand;
        else if (en && vld_reg[K_CMP])
            skid_reg <= cand;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg.py, out_reg.px};
    assign m_axis_tuser  = {out_reg.coin, out_reg.hit};

endmodule
